[rtl/pswf_pkg.sv]
// ----------------------------------------------------------------------------
// pswf_pkg
// Shared types, constants and fixed-point helpers for the PID controller with
// setpoint weighting, filtered derivative and anti-windup.
// ----------------------------------------------------------------------------
package pswf_pkg;

   localparam int SIGNAL_WIDTH    = 32;
   localparam int COEF_FRAC_BITS  = 24;
   localparam int PORT_WIDTH      = 32;
   localparam int COEF_WIDTH      = 31;
   localparam int DECAY_WIDTH     = 25;
   localparam int CSR_INDEX_WIDTH = 3;

   // room for the sum of three signals and for port-width values
   localparam int WIDE_WIDTH =
      ((SIGNAL_WIDTH > PORT_WIDTH) ? SIGNAL_WIDTH : PORT_WIDTH) + 2;
   // exact product of a difference and an unsigned coefficient
   localparam int PROD_WIDTH = SIGNAL_WIDTH + COEF_WIDTH + 1;

   typedef logic signed [SIGNAL_WIDTH-1:0] sig_type;
   typedef logic signed [SIGNAL_WIDTH:0]   diff_type;
   typedef logic signed [WIDE_WIDTH-1:0]   wide_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [PORT_WIDTH-1:0]   port_type;
   typedef logic [COEF_WIDTH-1:0]          coef_type;
   typedef logic [DECAY_WIDTH-1:0]         decay_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROP_GAIN     = 3'd0,
      CSR_WEIGHTED_GAIN = 3'd1,
      CSR_INTEGRAL_GAIN = 3'd2,
      CSR_DERIV_DECAY   = 3'd3,
      CSR_DERIV_GAIN    = 3'd4,
      CSR_OUT_MAX       = 3'd5,
      CSR_OUT_MIN       = 3'd6,
      CSR_LIMIT_ENABLE  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      LIMIT_NONE = 2'd0,
      LIMIT_HIGH = 2'd1,
      LIMIT_LOW  = 2'd2
   } limit_type;

   typedef struct packed {
      coef_type  prop_gain;
      coef_type  weighted_gain;
      coef_type  integral_gain;
      decay_type deriv_decay;
      coef_type  deriv_gain;
      port_type  out_max;
      port_type  out_min;
      logic      limit_enable;
   } cfg_type;

   typedef struct packed {
      sig_type prev_meas;
      sig_type integral;
      sig_type deriv;
   } state_type;

   typedef struct packed {
      port_type  control;
      limit_type limit;
      state_type next_state;
   } result_type;

   localparam wide_type SIG_MAX_W = (wide_type'(1) <<< (SIGNAL_WIDTH - 1)) - wide_type'(1);
   localparam wide_type SIG_MIN_W = -SIG_MAX_W - wide_type'(1);
   localparam prod_type SIG_MAX_P = (prod_type'(1) <<< (SIGNAL_WIDTH - 1)) - prod_type'(1);
   localparam prod_type SIG_MIN_P = -SIG_MAX_P - prod_type'(1);

   function automatic sig_type sat_wide(input wide_type v);
      wide_type r;
      if (v > SIG_MAX_W) begin
         r = SIG_MAX_W;
      end else if (v < SIG_MIN_W) begin
         r = SIG_MIN_W;
      end else begin
         r = v;
      end
      return sig_type'(r[SIGNAL_WIDTH-1:0]);
   endfunction

   function automatic sig_type sat_port(input port_type v);
      wide_type w;
      w = wide_type'(v);
      return sat_wide(w);
   endfunction

   // floor(a * c / 2^COEF_FRAC_BITS), saturated to the signal range
   function automatic sig_type cmul(input diff_type a, input coef_type c);
      prod_type ext_a;
      prod_type ext_c;
      prod_type prod;
      prod_type shifted;
      prod_type r;
      ext_a   = prod_type'(a);
      ext_c   = prod_type'({1'b0, c});
      prod    = ext_a * ext_c;
      shifted = prod >>> COEF_FRAC_BITS;
      if (shifted > SIG_MAX_P) begin
         r = SIG_MAX_P;
      end else if (shifted < SIG_MIN_P) begin
         r = SIG_MIN_P;
      end else begin
         r = shifted;
      end
      return sig_type'(r[SIGNAL_WIDTH-1:0]);
   endfunction

endpackage

[rtl/pid_setpoint_weight_filtered_d_unit.sv]
// ----------------------------------------------------------------------------
// pid_setpoint_weight_filtered_d_unit
// Discrete PID controller with setpoint weighting, filtered derivative and
// anti-windup clamp; one control value per setpoint/measurement item.
// ----------------------------------------------------------------------------
// an accepted item is held in the input register, then in the result register
// throughput: one item per cycle while rsp_ready holds; the single-pass datapath
//   between the input register and the result register carries the controller state forward
// reset: synchronous, clears both valid flags and the controller state and
//   loads the register reset values; no clearing pass
module pid_setpoint_weight_filtered_d_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pswf_pkg::PORT_WIDTH-1:0] req_setpoint,
   input  logic signed [pswf_pkg::PORT_WIDTH-1:0] req_measurement,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pswf_pkg::PORT_WIDTH-1:0] rsp_control,
   output logic [1:0]                           rsp_limit_state,
   input  logic                                 csr_write_enable,
   input  logic [pswf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pswf_pkg::PORT_WIDTH-1:0]      csr_wdata
);

   pswf_pkg::cfg_type    cfg;
   pswf_pkg::result_type dp_result;

   logic                 in_valid_ff;
   pswf_pkg::port_type   in_setpoint_ff;
   pswf_pkg::port_type   in_measurement_ff;
   logic                 out_valid_ff;
   pswf_pkg::port_type   out_control_ff;
   pswf_pkg::limit_type  out_limit_ff;
   pswf_pkg::state_type  state_ff;

   logic req_fire;
   logic advance;

   pswf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   pswf_datapath u_datapath (
      .setpoint    (in_setpoint_ff),
      .measurement (in_measurement_ff),
      .state       (state_ff),
      .cfg         (cfg),
      .result      (dp_result)
   );

   // item moves to the result register when that one is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= dp_result.next_state;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_setpoint_ff    <= req_setpoint;
         in_measurement_ff <= req_measurement;
      end
      if (advance) begin
         out_control_ff <= dp_result.control;
         out_limit_ff   <= dp_result.limit;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_control     = out_control_ff;
   assign rsp_limit_state = out_limit_ff;

   a_integral_frozen: assert property (@(posedge clock) disable iff (reset)
      (advance && (dp_result.limit != pswf_pkg::LIMIT_NONE)) |=> $stable(state_ff.integral))
      else $error("integral changed while output clamped");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after advance");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_measurement_ff)))
      else $error("pending input item lost");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("controller state changed without an item");

endmodule

[rtl/pswf_csr.sv]
// ----------------------------------------------------------------------------
// pswf_csr
// Configuration registers: gains, derivative decay, output limits, limit
// enable. Written through a plain write port, no read-back.
// ----------------------------------------------------------------------------
module pswf_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [pswf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pswf_pkg::PORT_WIDTH-1:0]       csr_wdata,
   output pswf_pkg::cfg_type                     cfg
);

   pswf_pkg::cfg_type cfg_ff;
   pswf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (pswf_pkg::csr_index_type'(csr_index))
            pswf_pkg::CSR_PROP_GAIN: begin
               cfg_in.prop_gain = csr_wdata[pswf_pkg::COEF_WIDTH-1:0];
            end
            pswf_pkg::CSR_WEIGHTED_GAIN: begin
               cfg_in.weighted_gain = csr_wdata[pswf_pkg::COEF_WIDTH-1:0];
            end
            pswf_pkg::CSR_INTEGRAL_GAIN: begin
               cfg_in.integral_gain = csr_wdata[pswf_pkg::COEF_WIDTH-1:0];
            end
            pswf_pkg::CSR_DERIV_DECAY: begin
               cfg_in.deriv_decay = csr_wdata[pswf_pkg::DECAY_WIDTH-1:0];
            end
            pswf_pkg::CSR_DERIV_GAIN: begin
               cfg_in.deriv_gain = csr_wdata[pswf_pkg::COEF_WIDTH-1:0];
            end
            pswf_pkg::CSR_OUT_MAX: begin
               cfg_in.out_max = $signed(csr_wdata);
            end
            pswf_pkg::CSR_OUT_MIN: begin
               cfg_in.out_min = $signed(csr_wdata);
            end
            pswf_pkg::CSR_LIMIT_ENABLE: begin
               cfg_in.limit_enable = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= pswf_pkg::coef_type'(1) << pswf_pkg::COEF_FRAC_BITS;
         cfg_ff.weighted_gain <= pswf_pkg::coef_type'(1) << pswf_pkg::COEF_FRAC_BITS;
         cfg_ff.integral_gain <= '0;
         cfg_ff.deriv_decay   <= '0;
         cfg_ff.deriv_gain    <= '0;
         cfg_ff.out_max       <= {1'b0, {(pswf_pkg::PORT_WIDTH-1){1'b1}}};
         cfg_ff.out_min       <= {1'b1, {(pswf_pkg::PORT_WIDTH-1){1'b0}}};
         cfg_ff.limit_enable  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/pswf_datapath.sv]
// ----------------------------------------------------------------------------
// pswf_datapath
// Single-pass PID arithmetic: five coefficient products, saturating P, I, D
// sums, the output clamp and the next controller state.
// ----------------------------------------------------------------------------
module pswf_datapath (
   input  pswf_pkg::port_type   setpoint,
   input  pswf_pkg::port_type   measurement,
   input  pswf_pkg::state_type  state,
   input  pswf_pkg::cfg_type    cfg,
   output pswf_pkg::result_type result
);

   pswf_pkg::sig_type  sp;
   pswf_pkg::sig_type  ms;
   pswf_pkg::diff_type err;
   pswf_pkg::diff_type meas_delta;
   pswf_pkg::sig_type  p_term;
   pswf_pkg::sig_type  i_term;
   pswf_pkg::sig_type  d_term;
   pswf_pkg::sig_type  u_sum;
   pswf_pkg::wide_type u_wide;
   pswf_pkg::wide_type u_final;
   pswf_pkg::limit_type limit;

   always_comb begin
      sp = pswf_pkg::sat_port(setpoint);
      ms = pswf_pkg::sat_port(measurement);

      // differences kept exact with one extra bit
      err        = pswf_pkg::diff_type'(sp) - pswf_pkg::diff_type'(ms);
      meas_delta = pswf_pkg::diff_type'(ms) - pswf_pkg::diff_type'(state.prev_meas);

      p_term = pswf_pkg::sat_wide(
         pswf_pkg::wide_type'(pswf_pkg::cmul(pswf_pkg::diff_type'(sp), cfg.weighted_gain))
         - pswf_pkg::wide_type'(pswf_pkg::cmul(pswf_pkg::diff_type'(ms), cfg.prop_gain)));

      i_term = pswf_pkg::sat_wide(
         pswf_pkg::wide_type'(state.integral)
         + pswf_pkg::wide_type'(pswf_pkg::cmul(err, cfg.integral_gain)));

      d_term = pswf_pkg::sat_wide(
         pswf_pkg::wide_type'(pswf_pkg::cmul(pswf_pkg::diff_type'(state.deriv),
                                             pswf_pkg::coef_type'(cfg.deriv_decay)))
         - pswf_pkg::wide_type'(pswf_pkg::cmul(meas_delta, cfg.deriv_gain)));

      u_sum = pswf_pkg::sat_wide(pswf_pkg::wide_type'(p_term)
                                 + pswf_pkg::wide_type'(i_term)
                                 + pswf_pkg::wide_type'(d_term));

      // upper limit tested first, so with crossed limits a value above out_max resolves to out_max
      u_wide  = pswf_pkg::wide_type'(u_sum);
      u_final = u_wide;
      limit   = pswf_pkg::LIMIT_NONE;
      if (cfg.limit_enable) begin
         if (u_wide > pswf_pkg::wide_type'(cfg.out_max)) begin
            u_final = pswf_pkg::wide_type'(cfg.out_max);
            limit   = pswf_pkg::LIMIT_HIGH;
         end else if (u_wide < pswf_pkg::wide_type'(cfg.out_min)) begin
            u_final = pswf_pkg::wide_type'(cfg.out_min);
            limit   = pswf_pkg::LIMIT_LOW;
         end
      end

      result.control              = $signed(u_final[pswf_pkg::PORT_WIDTH-1:0]);
      result.limit                = limit;
      result.next_state.prev_meas = ms;
      result.next_state.deriv     = d_term;
      // anti-windup: integral frozen while clamped
      result.next_state.integral  = (limit == pswf_pkg::LIMIT_NONE) ? i_term
                                                                     : state.integral;
   end

endmodule

[sim/pid_setpoint_weight_filtered_d_unit_tb.sv]
// ----------------------------------------------------------------------------
// pid_setpoint_weight_filtered_d_unit_tb
// Self-checking bench for the PID unit. A short table of directed items is
// followed by randomized control runs under several register settings. Each
// accepted item is run through a bit-accurate controller model kept in the
// bench, and every result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_setpoint_weight_filtered_d_unit_tb;

   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 100;

   localparam logic signed [95:0] PROD_MAX = 96'sh7FFF_FFFF;
   localparam logic signed [95:0] PROD_MIN = -96'sh8000_0000;
   localparam logic signed [35:0] SUM_MAX  = 36'sh7FFF_FFFF;
   localparam logic signed [35:0] SUM_MIN  = -36'sh8000_0000;

   typedef struct packed {
      logic signed [31:0]  control;
      pswf_pkg::limit_type limit;
   } pid_out_s;

   typedef struct packed {
      int                  section;
      logic [31:0]         setpoint;
      logic [31:0]         measurement;
      bit                  typed;
      logic [31:0]         control;
      pswf_pkg::limit_type limit;
   } vector_row_s;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_setpoint;
   logic signed [31:0] req_measurement;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_control;
   logic [1:0]         rsp_limit_state;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   // controller registers and state as the bench sees them
   logic [30:0]        ctl_prop_gain;
   logic [30:0]        ctl_weighted_gain;
   logic [30:0]        ctl_integral_gain;
   logic [24:0]        ctl_deriv_decay;
   logic [30:0]        ctl_deriv_gain;
   logic signed [31:0] ctl_out_max;
   logic signed [31:0] ctl_out_min;
   logic               ctl_limit_enable;
   logic signed [31:0] ctl_prev_meas;
   logic signed [31:0] ctl_integral;
   logic signed [31:0] ctl_deriv;

   pid_out_s    control_expected_q[$];
   vector_row_s directed_rows[$];
   int          mismatch_count = 0;
   bit          no_idle = 1'b0;
   bit          hold_off_request = 1'b0;

   pid_setpoint_weight_filtered_d_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_setpoint     (req_setpoint),
      .req_measurement  (req_measurement),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_control      (rsp_control),
      .rsp_limit_state  (rsp_limit_state),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // floor of a * c / 2^24, clipped to the signal range
   function automatic logic signed [31:0] scaled_product(input logic signed [33:0] a,
                                                         input logic [30:0] c);
      logic signed [95:0] prod;
      logic signed [95:0] coef;
      prod = 96'(a);
      coef = {65'd0, c};
      prod = (prod * coef) >>> 24;
      if (prod > PROD_MAX) begin
         prod = PROD_MAX;
      end else if (prod < PROD_MIN) begin
         prod = PROD_MIN;
      end
      return prod[31:0];
   endfunction

   function automatic logic signed [31:0] clip_sum(input logic signed [35:0] v);
      if (v > SUM_MAX) begin
         return SUM_MAX[31:0];
      end else if (v < SUM_MIN) begin
         return SUM_MIN[31:0];
      end
      return v[31:0];
   endfunction

   // one controller step; advances the bench copy of the state
   function automatic pid_out_s predict_control(input logic signed [31:0] sp,
                                                input logic signed [31:0] ms);
      logic signed [33:0] err;
      logic signed [33:0] slope;
      logic signed [35:0] sum;
      logic signed [31:0] p_term;
      logic signed [31:0] i_term;
      logic signed [31:0] d_term;
      pid_out_s           r;
      err    = 34'(sp) - 34'(ms);
      slope  = 34'(ms) - 34'(ctl_prev_meas);
      sum    = 36'(scaled_product(34'(sp), ctl_weighted_gain))
               - 36'(scaled_product(34'(ms), ctl_prop_gain));
      p_term = clip_sum(sum);
      sum    = 36'(ctl_integral) + 36'(scaled_product(err, ctl_integral_gain));
      i_term = clip_sum(sum);
      sum    = 36'(scaled_product(34'(ctl_deriv), {6'd0, ctl_deriv_decay}))
               - 36'(scaled_product(slope, ctl_deriv_gain));
      d_term = clip_sum(sum);
      sum    = 36'(p_term) + 36'(i_term) + 36'(d_term);
      r.control = clip_sum(sum);
      r.limit   = pswf_pkg::LIMIT_NONE;
      // upper limit is tested first, so with crossed limits a value above out_max gives out_max
      if (ctl_limit_enable) begin
         if (r.control > ctl_out_max) begin
            r.control = ctl_out_max;
            r.limit   = pswf_pkg::LIMIT_HIGH;
         end else if (r.control < ctl_out_min) begin
            r.control = ctl_out_min;
            r.limit   = pswf_pkg::LIMIT_LOW;
         end
      end
      ctl_prev_meas = ms;
      ctl_deriv     = d_term;
      if (r.limit == pswf_pkg::LIMIT_NONE) begin
         ctl_integral = i_term;
      end
      return r;
   endfunction

   task automatic csr_write(input pswf_pkg::csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_wdata        = value;
      case (idx)
         pswf_pkg::CSR_PROP_GAIN:     ctl_prop_gain     = value[30:0];
         pswf_pkg::CSR_WEIGHTED_GAIN: ctl_weighted_gain = value[30:0];
         pswf_pkg::CSR_INTEGRAL_GAIN: ctl_integral_gain = value[30:0];
         pswf_pkg::CSR_DERIV_DECAY:   ctl_deriv_decay   = value[24:0];
         pswf_pkg::CSR_DERIV_GAIN:    ctl_deriv_gain    = value[30:0];
         pswf_pkg::CSR_OUT_MAX:       ctl_out_max       = value;
         pswf_pkg::CSR_OUT_MIN:       ctl_out_min       = value;
         pswf_pkg::CSR_LIMIT_ENABLE:  ctl_limit_enable  = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_item(input logic [31:0] sp, input logic [31:0] ms, input bit typed,
                            input logic [31:0] ctl, input pswf_pkg::limit_type lim);
      pid_out_s r;
      int       gap;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_setpoint    = sp;
      req_measurement = ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_control(sp, ms);
      if (typed) begin
         r.control = ctl;
         r.limit   = lim;
      end
      control_expected_q.push_back(r);
   endtask

   // stop offering items and wait until every result is back
   task automatic settle_pipeline();
      @(negedge clock);
      req_valid = 1'b0;
      while (control_expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_row(input int section, input logic [31:0] sp, input logic [31:0] ms,
                          input bit typed, input logic [31:0] ctl,
                          input pswf_pkg::limit_type lim);
      vector_row_s row;
      row.section     = section;
      row.setpoint    = sp;
      row.measurement = ms;
      row.typed       = typed;
      row.control     = ctl;
      row.limit       = lim;
      directed_rows.push_back(row);
   endtask

   task automatic apply_section(input int section);
      case (section)
         1: begin
            csr_write(pswf_pkg::CSR_OUT_MAX, 32'h0001_0000);
            csr_write(pswf_pkg::CSR_OUT_MIN, 32'hFFFF_0000);
            csr_write(pswf_pkg::CSR_LIMIT_ENABLE, 32'h1);
         end
         2: begin
            // crossed limits
            csr_write(pswf_pkg::CSR_OUT_MAX, 32'hFFFF_0000);
            csr_write(pswf_pkg::CSR_OUT_MIN, 32'h0001_0000);
         end
         3: begin
            csr_write(pswf_pkg::CSR_INTEGRAL_GAIN, 32'h0100_0000);
            csr_write(pswf_pkg::CSR_DERIV_GAIN, 32'h0080_0000);
            csr_write(pswf_pkg::CSR_DERIV_DECAY, 32'h01FF_FFFF);
            csr_write(pswf_pkg::CSR_OUT_MAX, 32'h0002_0000);
            csr_write(pswf_pkg::CSR_OUT_MIN, 32'hFFFE_0000);
         end
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return 32'd0;
         default: return $urandom_range(0, 32'h0200_0000);
      endcase
   endfunction

   function automatic logic [31:0] rand_level();
      if ($urandom_range(0, 4) == 0) begin
         return $urandom;
      end
      return $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
   endfunction

   task automatic config_for_phase(input int phase);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] swap;
      case (phase)
         0: begin
            csr_write(pswf_pkg::CSR_PROP_GAIN, 32'hFFFF_FFFF);
            csr_write(pswf_pkg::CSR_WEIGHTED_GAIN, 32'h7FFF_FFFF);
            csr_write(pswf_pkg::CSR_INTEGRAL_GAIN, 32'h7FFF_FFFF);
            csr_write(pswf_pkg::CSR_DERIV_DECAY, 32'hFFFF_FFFF);
            csr_write(pswf_pkg::CSR_DERIV_GAIN, 32'h7FFF_FFFF);
            csr_write(pswf_pkg::CSR_OUT_MAX, 32'h7FFF_FFFF);
            csr_write(pswf_pkg::CSR_OUT_MIN, 32'h8000_0000);
            csr_write(pswf_pkg::CSR_LIMIT_ENABLE, 32'h1);
         end
         1: begin
            csr_write(pswf_pkg::CSR_PROP_GAIN, 32'h0);
            csr_write(pswf_pkg::CSR_WEIGHTED_GAIN, 32'h0);
            csr_write(pswf_pkg::CSR_INTEGRAL_GAIN, 32'h0);
            csr_write(pswf_pkg::CSR_DERIV_DECAY, 32'h0);
            csr_write(pswf_pkg::CSR_DERIV_GAIN, 32'h0);
            csr_write(pswf_pkg::CSR_OUT_MAX, 32'h8000_0000);
            csr_write(pswf_pkg::CSR_OUT_MIN, 32'h7FFF_FFFF);
            csr_write(pswf_pkg::CSR_LIMIT_ENABLE, 32'hFFFF_FFFE);
         end
         2: begin
            // plain tuning near unity gain, so the anti-windup gets exercised
            csr_write(pswf_pkg::CSR_PROP_GAIN,
                      32'h0100_0000 + $urandom_range(0, 32'h0040_0000));
            csr_write(pswf_pkg::CSR_WEIGHTED_GAIN,
                      32'h00C0_0000 + $urandom_range(0, 32'h0040_0000));
            csr_write(pswf_pkg::CSR_INTEGRAL_GAIN, 32'h0020_0000);
            csr_write(pswf_pkg::CSR_DERIV_DECAY, 32'h00C0_0000);
            csr_write(pswf_pkg::CSR_DERIV_GAIN, 32'h0100_0000);
            csr_write(pswf_pkg::CSR_OUT_MAX, 32'h0005_0000);
            csr_write(pswf_pkg::CSR_OUT_MIN, 32'hFFFB_0000);
            csr_write(pswf_pkg::CSR_LIMIT_ENABLE, 32'h1);
         end
         default: begin
            lo = rand_level();
            hi = rand_level();
            if ($signed(hi) < $signed(lo) && $urandom_range(0, 4) != 0) begin
               swap = hi;
               hi   = lo;
               lo   = swap;
            end
            csr_write(pswf_pkg::CSR_PROP_GAIN, rand_gain());
            csr_write(pswf_pkg::CSR_WEIGHTED_GAIN, rand_gain());
            csr_write(pswf_pkg::CSR_INTEGRAL_GAIN, rand_gain());
            csr_write(pswf_pkg::CSR_DERIV_DECAY, ($urandom_range(0, 3) == 0) ? $urandom
                                                 : $urandom_range(0, 32'h0100_0000));
            csr_write(pswf_pkg::CSR_DERIV_GAIN, rand_gain());
            csr_write(pswf_pkg::CSR_OUT_MAX, hi);
            csr_write(pswf_pkg::CSR_OUT_MIN, lo);
            csr_write(pswf_pkg::CSR_LIMIT_ENABLE, $urandom);
         end
      endcase
   endtask

   // result checker
   always @(posedge clock) begin
      pid_out_s exp_out;
      if (!reset && rsp_valid && rsp_ready) begin
         if (control_expected_q.size() == 0) begin
            $display("%0t: unexpected item, control %h limit %0d", $time, rsp_control,
                     rsp_limit_state);
            mismatch_count++;
         end else begin
            exp_out = control_expected_q.pop_front();
            if (rsp_control !== exp_out.control) begin
               $display("%0t: control mismatch, expected %h, actual %h", $time,
                        exp_out.control, rsp_control);
               mismatch_count++;
            end
            if (rsp_limit_state !== exp_out.limit) begin
               $display("%0t: limit_state mismatch, expected %0d, actual %0d", $time,
                        exp_out.limit, rsp_limit_state);
               mismatch_count++;
            end
         end
      end
   end

   // result-side backpressure
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_ready = 1'b1;
         end else if (hold_off_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_ready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            n = $urandom_range(1, 30);
            rsp_ready = 1'b1;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall = 0;
         end else begin
            stall++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int          cur_section;
      longint      next_meas;
      logic [31:0] sp_track;
      logic [31:0] ms_track;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_setpoint     = '0;
      req_measurement  = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      ctl_prop_gain     = 31'h0100_0000;
      ctl_weighted_gain = 31'h0100_0000;
      ctl_integral_gain = '0;
      ctl_deriv_decay   = '0;
      ctl_deriv_gain    = '0;
      ctl_out_max       = 32'h7FFF_FFFF;
      ctl_out_min       = 32'h8000_0000;
      ctl_limit_enable  = 1'b0;
      ctl_prev_meas     = '0;
      ctl_integral      = '0;
      ctl_deriv         = '0;

      // reset values: unity gains, nothing else, so control = clipped error
      add_row(0, 32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, pswf_pkg::LIMIT_NONE);
      add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF, pswf_pkg::LIMIT_NONE);
      add_row(0, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000, pswf_pkg::LIMIT_NONE);
      add_row(0, 32'h0005_0000, 32'h0002_0000, 1, 32'h0003_0000, pswf_pkg::LIMIT_NONE);
      add_row(0, 32'h8000_0000, 32'h8000_0000, 1, 32'h0000_0000, pswf_pkg::LIMIT_NONE);
      add_row(0, 32'hFFFF_FFFF, 32'h0000_0001, 1, 32'hFFFF_FFFE, pswf_pkg::LIMIT_NONE);
      // limits of +-1.0
      add_row(1, 32'h000A_0000, 32'h0000_0000, 1, 32'h0001_0000, pswf_pkg::LIMIT_HIGH);
      add_row(1, 32'h0000_0000, 32'h000A_0000, 1, 32'hFFFF_0000, pswf_pkg::LIMIT_LOW);
      add_row(1, 32'h0000_8000, 32'h0000_0000, 1, 32'h0000_8000, pswf_pkg::LIMIT_NONE);
      // crossed limits
      add_row(2, 32'h0000_0000, 32'h0000_0000, 1, 32'hFFFF_0000, pswf_pkg::LIMIT_HIGH);
      add_row(2, 32'h0000_0000, 32'h0005_0000, 1, 32'h0001_0000, pswf_pkg::LIMIT_LOW);
      // full controller, decay above unity, integral windup and release
      add_row(3, 32'h0003_0000, 32'h0000_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h0003_0000, 32'h0000_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h0003_0000, 32'h0001_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h0000_0000, 32'h0004_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h0000_1000, 32'h0000_1000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h0000_0000, 32'h0000_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'hFFFF_0000, 32'h0002_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h0002_0000, 32'hFFFE_0000, 0, '0, pswf_pkg::LIMIT_NONE);
      add_row(3, 32'h0000_0000, 32'h0000_0000, 0, '0, pswf_pkg::LIMIT_NONE);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      cur_section = 0;
      foreach (directed_rows[k]) begin
         if (directed_rows[k].section != cur_section) begin
            settle_pipeline();
            apply_section(directed_rows[k].section);
            cur_section = directed_rows[k].section;
         end
         send_item(directed_rows[k].setpoint, directed_rows[k].measurement,
                   directed_rows[k].typed, directed_rows[k].control, directed_rows[k].limit);
      end

      sp_track = 32'h0001_0000;
      ms_track = '0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == PHASE_COUNT - 1) begin
            no_idle = 1'b1;
         end
         settle_pipeline();
         config_for_phase(phase);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 3 && k == 20) begin
               hold_off_request = 1'b1;
            end
            if (phase == 5 && k == 50) begin
               settle_pipeline();
            end
            // occasional setpoint step, measurement follows it like a plant
            if ($urandom_range(0, 19) == 0) begin
               sp_track = ($urandom_range(0, 7) == 0) ? $urandom
                          : $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
            end
            next_meas = longint'($signed(ms_track))
                        + (longint'($signed(sp_track)) - longint'($signed(ms_track))) / 8
                        + longint'($urandom_range(0, 32'h0002_0000)) - 64'sh1_0000;
            if (next_meas > 64'sh7FFF_FFFF) begin
               next_meas = 64'sh7FFF_FFFF;
            end else if (next_meas < -64'sh8000_0000) begin
               next_meas = -64'sh8000_0000;
            end
            ms_track = next_meas[31:0];
            if ($urandom_range(0, 9) == 0) begin
               send_item($urandom, $urandom, 0, '0, pswf_pkg::LIMIT_NONE);
            end else begin
               send_item(sp_track, ms_track, 0, '0, pswf_pkg::LIMIT_NONE);
            end
         end
      end

      settle_pipeline();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
